// ===== src/pps_pkg.sv =====
// ----------------------------------------------------------------------------
// pps_pkg
// Shared types for the preemptive priority scheduler: process table record,
// scan control word and controller state encoding.
// ----------------------------------------------------------------------------
package pps_pkg;

  typedef struct packed {
    logic [7:0]  pid;
    logic [15:0] arrival;
    logic [7:0]  burst;
    logic [7:0]  prio;
    logic [7:0]  remaining;
    logic [16:0] start;
  } pps_entry_t;

  // scan control, controller -> selector
  typedef struct packed {
    logic clear;
    logic vld;
    logic done;
  } pps_scan_t;

  typedef enum logic [4:0] {
    S_LOAD  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_SERVE = 5'b00100,
    S_FIN   = 5'b01000,
    S_EMIT  = 5'b10000
  } pps_state_t;

endpackage

// ===== src/pps_table.sv =====
// ----------------------------------------------------------------------------
// pps_table
// Process table memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pps_table
  import pps_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int IW    = 4
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [IW-1:0] wr_addr,
  input  pps_entry_t    wr_data,
  input  logic          rd_en,
  input  logic [IW-1:0] rd_addr,
  output pps_entry_t    rd_data
);

  pps_entry_t mem [DEPTH];
  pps_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/pps_pick.sv =====
// ----------------------------------------------------------------------------
// pps_pick
// Selector fed by the table read stream: keeps the best ready entry of the
// current scan and the earliest arrival among unfinished entries.
// ----------------------------------------------------------------------------
module pps_pick
  import pps_pkg::*;
#(
  parameter int IW = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  pps_scan_t     ctl,
  input  logic [IW-1:0] idx,
  input  pps_entry_t    rec,
  input  logic [16:0]   now,
  output logic          best_found,
  output logic [IW-1:0] best_idx,
  output pps_entry_t    best_rec,
  output logic [15:0]   min_arr
);

  logic          found_r;
  logic [IW-1:0] idx_r;
  pps_entry_t    rec_r;
  logic [15:0]   min_r;
  logic          ready;
  logic          better;

  always_comb begin
    ready  = ctl.vld && !ctl.done && ({1'b0, rec.arrival} <= now);
    better = !found_r || (rec.prio > rec_r.prio) ||
             ((rec.prio == rec_r.prio) && (rec.arrival < rec_r.arrival));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (ctl.clear) begin
      found_r <= 1'b0;
    end else if (ready && better) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      min_r <= '1;
    end else begin
      if (ready && better) begin
        idx_r <= idx;
        rec_r <= rec;
      end
      if (ctl.vld && !ctl.done && (rec.arrival < min_r)) begin
        min_r <= rec.arrival;
      end
    end
  end

  assign best_found = found_r;
  assign best_idx   = idx_r;
  assign best_rec   = rec_r;
  assign min_arr    = min_r;

endmodule

// ===== src/preemptive_priority_scheduler.sv =====
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler
// Loads a process table, then runs it tick by tick under preemptive priority
// scheduling and reports one word per completed process.
// ----------------------------------------------------------------------------
// Process words are taken one per cycle until the word with last_entry set;
// words beyond MAX_PROCESSES are dropped. The run then simulates one tick at a
// time: each tick reads the whole table through its single read port, one
// entry per cycle, and a tick that completes a process also passes through
// the finish and emit states, where it can be held by output back-pressure.
// An idle stretch is skipped in one scan. No input word is taken during the
// run; the next set can load as soon as the last result is registered.
module preemptive_priority_scheduler
  import pps_pkg::*;
#(
  parameter int MAX_PROCESSES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_proc_id,
  input  logic [15:0] in_arrival_tick,
  input  logic [7:0]  in_burst_length,
  input  logic [7:0]  in_prio_level,
  input  logic        in_last_entry,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_done_id,
  output logic [16:0] out_start_tick,
  output logic [16:0] out_finish_tick,
  output logic [16:0] out_turnaround,
  output logic [16:0] out_wait_ticks,
  output logic [23:0] out_sum_turnaround,
  output logic [23:0] out_sum_wait,
  output logic        out_last_result
);

  localparam int IW = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  localparam int CW = $clog2(MAX_PROCESSES + 1);

  pps_state_t state_r;
  logic [CW-1:0] loaded_r;
  logic [CW-1:0] finished_r;
  logic [CW-1:0] scan_idx_r;
  logic [16:0] now_r;
  logic [23:0] total_turn_r;
  logic [23:0] total_wait_r;
  logic [MAX_PROCESSES-1:0] started_r;
  logic [MAX_PROCESSES-1:0] done_r;
  logic rd_vld_r;
  logic rd_last_r;
  logic [IW-1:0] rd_idx_r;
  logic [16:0] fin_start_r;
  logic [16:0] turn_r;
  logic [16:0] wait_r;
  logic out_valid_r;
  logic [7:0] out_id_r;
  logic [16:0] out_start_r;
  logic [16:0] out_finish_r;
  logic [16:0] out_turn_r;
  logic [16:0] out_wait_r;
  logic [23:0] out_sum_turn_r;
  logic [23:0] out_sum_wait_r;
  logic out_last_r;

  logic in_acc;
  logic rd_en;
  logic rd_last;
  logic wr_en;
  logic [IW-1:0] wr_addr;
  pps_entry_t wr_data;
  pps_entry_t rd_data;
  pps_entry_t load_rec;
  pps_entry_t serve_rec;
  pps_scan_t scan_ctl;
  logic best_found;
  logic [IW-1:0] best_idx;
  pps_entry_t best_rec;
  logic [15:0] min_arr;
  logic [16:0] serve_start;
  logic out_free;
  logic [23:0] sum_turn_nxt;
  logic [23:0] sum_wait_nxt;
  logic run_last;
  logic table_room;

  assign in_ready   = (state_r == S_LOAD);
  assign in_acc     = in_valid && in_ready;
  assign table_room = (loaded_r < CW'(MAX_PROCESSES));
  assign out_free   = !out_valid_r || out_ready;

  assign rd_en   = (state_r == S_SCAN) && (scan_idx_r < loaded_r);
  assign rd_last = (scan_idx_r == loaded_r - CW'(1));

  always_comb begin
    load_rec           = '0;
    load_rec.pid       = in_proc_id;
    load_rec.arrival   = in_arrival_tick;
    load_rec.burst     = (in_burst_length == 8'd0) ? 8'd1 : in_burst_length;
    load_rec.remaining = load_rec.burst;
    load_rec.prio      = in_prio_level;

    serve_start         = started_r[best_idx] ? best_rec.start : now_r;
    serve_rec           = best_rec;
    serve_rec.remaining = best_rec.remaining - 8'd1;
    serve_rec.start     = serve_start;
  end

  always_comb begin
    if (state_r == S_LOAD) begin
      wr_en   = in_acc && table_room;
      wr_addr = loaded_r[IW-1:0];
      wr_data = load_rec;
    end else begin
      wr_en   = (state_r == S_SERVE) && best_found;
      wr_addr = best_idx;
      wr_data = serve_rec;
    end
  end

  assign scan_ctl.clear = (state_r == S_SCAN) && (scan_idx_r == '0);
  assign scan_ctl.vld   = rd_vld_r;
  assign scan_ctl.done  = done_r[rd_idx_r];

  assign sum_turn_nxt = total_turn_r + 24'(turn_r);
  assign sum_wait_nxt = total_wait_r + 24'(wait_r);
  assign run_last     = (finished_r == loaded_r);

  pps_table #(
    .DEPTH (MAX_PROCESSES),
    .IW    (IW)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (scan_idx_r[IW-1:0]),
    .rd_data (rd_data)
  );

  pps_pick #(
    .IW (IW)
  ) u_pick (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (scan_ctl),
    .idx        (rd_idx_r),
    .rec        (rd_data),
    .now        (now_r),
    .best_found (best_found),
    .best_idx   (best_idx),
    .best_rec   (best_rec),
    .min_arr    (min_arr)
  );

  // read pipeline tags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_idx_r  <= scan_idx_r[IW-1:0];
      rd_last_r <= rd_last;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_LOAD;
      loaded_r     <= '0;
      finished_r   <= '0;
      scan_idx_r   <= '0;
      now_r        <= '0;
      total_turn_r <= '0;
      total_wait_r <= '0;
      started_r    <= '0;
      done_r       <= '0;
    end else begin
      unique case (state_r)
        S_LOAD: begin
          if (in_acc) begin
            if (table_room) begin
              loaded_r <= loaded_r + CW'(1);
            end
            if (in_last_entry) begin
              scan_idx_r <= '0;
              state_r    <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (rd_en) begin
            scan_idx_r <= scan_idx_r + CW'(1);
          end
          if (rd_vld_r && rd_last_r) begin
            state_r <= S_SERVE;
          end
        end
        S_SERVE: begin
          scan_idx_r <= '0;
          if (!best_found) begin
            now_r   <= {1'b0, min_arr};
            state_r <= S_SCAN;
          end else begin
            started_r[best_idx] <= 1'b1;
            now_r <= now_r + 17'd1;
            if (best_rec.remaining == 8'd1) begin
              done_r[best_idx] <= 1'b1;
              finished_r <= finished_r + CW'(1);
              state_r    <= S_FIN;
            end else begin
              state_r <= S_SCAN;
            end
          end
        end
        S_FIN: begin
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            if (run_last) begin
              loaded_r     <= '0;
              finished_r   <= '0;
              now_r        <= '0;
              total_turn_r <= '0;
              total_wait_r <= '0;
              started_r    <= '0;
              done_r       <= '0;
              state_r      <= S_LOAD;
            end else begin
              total_turn_r <= sum_turn_nxt;
              total_wait_r <= sum_wait_nxt;
              state_r      <= S_SCAN;
            end
          end
        end
        default: begin
          state_r <= S_LOAD;
        end
      endcase
    end
  end

  // completion figures
  always_ff @(posedge clk) begin
    if ((state_r == S_SERVE) && best_found) begin
      fin_start_r <= serve_start;
    end
    if (state_r == S_FIN) begin
      turn_r <= now_r - {1'b0, best_rec.arrival};
      wait_r <= now_r - {1'b0, best_rec.arrival} - {9'd0, best_rec.burst};
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == S_EMIT) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_EMIT) && out_free) begin
      out_id_r       <= best_rec.pid;
      out_start_r    <= fin_start_r;
      out_finish_r   <= now_r;
      out_turn_r     <= turn_r;
      out_wait_r     <= wait_r;
      out_sum_turn_r <= sum_turn_nxt;
      out_sum_wait_r <= sum_wait_nxt;
      out_last_r     <= run_last;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_done_id        = out_id_r;
  assign out_start_tick     = out_start_r;
  assign out_finish_tick    = out_finish_r;
  assign out_turnaround     = out_turn_r;
  assign out_wait_ticks     = out_wait_r;
  assign out_sum_turnaround = out_sum_turn_r;
  assign out_sum_wait       = out_sum_wait_r;
  assign out_last_result    = out_last_r;

`ifndef ASSERT_OFF
  a_fin_le_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    finished_r <= loaded_r)
    else $error("finished count exceeds loaded count");

  a_no_wr_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> !wr_en)
    else $error("table write during scan");

  a_rd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> ({1'b0, rd_idx_r} < (IW + 1)'(loaded_r)))
    else $error("scan read beyond loaded entries");

  a_run_ends_clean: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_EMIT) && out_free && run_last) |=>
      ((loaded_r == '0) && (done_r == '0) && in_ready))
    else $error("table not released after final result");
`endif

endmodule

// ===== tb/preemptive_priority_scheduler_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_tb
// Self-checking bench: process sets in, completion words out, checked in order.
// ----------------------------------------------------------------------------
// A queue of process words is built up front: a directed part covering the
// field extremes, preemption, ties, idle stretches, zero burst and table
// overflow, then random sets of varying size. The driver hands the words to
// the block one by one. Each accepted word is loaded into a local scheduler
// model, and a word with last_entry set runs the set and queues the
// completion words it should produce. The monitor pops and compares these as
// the block delivers them. Both sides insert random gaps, with calm spells.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler_tb;

  localparam int TABLE_DEPTH  = 16;
  localparam int RANDOM_ITEMS = 350;
  localparam int IDLE_LIMIT   = 400000;
  localparam int TAIL_CYCLES  = 64;

  typedef struct packed {
    logic [7:0]  proc_id;
    logic [15:0] arrival_tick;
    logic [7:0]  burst_length;
    logic [7:0]  prio_level;
    logic        last_entry;
    logic        hold_for_drain;
  } proc_word_t;

  typedef struct packed {
    logic [7:0]  done_id;
    logic [16:0] start_tick;
    logic [16:0] finish_tick;
    logic [16:0] turnaround;
    logic [16:0] wait_ticks;
    logic [23:0] sum_turnaround;
    logic [23:0] sum_wait;
    logic        last_result;
  } completion_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_proc_id = '0;
  logic [15:0] in_arrival_tick = '0;
  logic [7:0]  in_burst_length = '0;
  logic [7:0]  in_prio_level = '0;
  logic        in_last_entry = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_done_id;
  logic [16:0] out_start_tick;
  logic [16:0] out_finish_tick;
  logic [16:0] out_turnaround;
  logic [16:0] out_wait_ticks;
  logic [23:0] out_sum_turnaround;
  logic [23:0] out_sum_wait;
  logic        out_last_result;

  preemptive_priority_scheduler #(
    .MAX_PROCESSES(TABLE_DEPTH)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_proc_id        (in_proc_id),
    .in_arrival_tick   (in_arrival_tick),
    .in_burst_length   (in_burst_length),
    .in_prio_level     (in_prio_level),
    .in_last_entry     (in_last_entry),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_done_id       (out_done_id),
    .out_start_tick    (out_start_tick),
    .out_finish_tick   (out_finish_tick),
    .out_turnaround    (out_turnaround),
    .out_wait_ticks    (out_wait_ticks),
    .out_sum_turnaround(out_sum_turnaround),
    .out_sum_wait      (out_sum_wait),
    .out_last_result   (out_last_result)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  proc_word_t  pending_q[$];
  completion_t completion_q[$];
  int          items_total;
  int          items_taken;
  int          mismatch_count;
  bit          calm;

  // scheduler model state
  logic [15:0] tbl_arrival[TABLE_DEPTH];
  logic [7:0]  tbl_remaining[TABLE_DEPTH];
  logic [7:0]  tbl_burst[TABLE_DEPTH];
  logic [7:0]  tbl_prio[TABLE_DEPTH];
  logic [7:0]  tbl_pid[TABLE_DEPTH];
  logic [16:0] tbl_start[TABLE_DEPTH];
  logic        tbl_started[TABLE_DEPTH];
  logic        tbl_done[TABLE_DEPTH];
  logic [4:0]  load_cnt;
  logic [4:0]  finish_cnt;
  logic [16:0] now_tick;
  logic [23:0] total_turn;
  logic [23:0] total_wait;

  function automatic int draw_gap();
    if (calm) return 0;
    return $urandom_range(0, 7);
  endfunction

  task automatic clear_table();
    int k;
    for (k = 0; k < TABLE_DEPTH; k++) begin
      tbl_started[k] = 1'b0;
      tbl_done[k]    = 1'b0;
    end
    load_cnt   = '0;
    finish_cnt = '0;
    now_tick   = '0;
    total_turn = '0;
    total_wait = '0;
  endtask

  task automatic run_schedule();
    int          k;
    int          best;
    logic [16:0] nearest;
    logic [16:0] turn;
    logic [16:0] idle_wait;
    completion_t res;
    while (finish_cnt < load_cnt) begin
      best = -1;
      for (k = 0; k < load_cnt; k++) begin
        if (!tbl_done[k] && {1'b0, tbl_arrival[k]} <= now_tick) begin
          if (best < 0 || tbl_prio[k] > tbl_prio[best] ||
              (tbl_prio[k] == tbl_prio[best] && tbl_arrival[k] < tbl_arrival[best]))
            best = k;
        end
      end
      if (best < 0) begin
        nearest = '1;
        for (k = 0; k < load_cnt; k++)
          if (!tbl_done[k] && {1'b0, tbl_arrival[k]} < nearest)
            nearest = {1'b0, tbl_arrival[k]};
        now_tick = nearest;
      end else begin
        if (!tbl_started[best]) begin
          tbl_started[best] = 1'b1;
          tbl_start[best]   = now_tick;
        end
        tbl_remaining[best] = tbl_remaining[best] - 8'd1;
        now_tick = now_tick + 17'd1;
        if (tbl_remaining[best] == 8'd0) begin
          tbl_done[best] = 1'b1;
          finish_cnt     = finish_cnt + 5'd1;
          turn           = now_tick - {1'b0, tbl_arrival[best]};
          idle_wait      = turn - {9'd0, tbl_burst[best]};
          total_turn     = total_turn + {7'd0, turn};
          total_wait     = total_wait + {7'd0, idle_wait};
          res.done_id        = tbl_pid[best];
          res.start_tick     = tbl_start[best];
          res.finish_tick    = now_tick;
          res.turnaround     = turn;
          res.wait_ticks     = idle_wait;
          res.sum_turnaround = total_turn;
          res.sum_wait       = total_wait;
          res.last_result    = (finish_cnt == load_cnt);
          completion_q.push_back(res);
        end
      end
    end
  endtask

  task automatic take_process(proc_word_t w);
    int          k;
    logic [7:0]  b;
    if (load_cnt < TABLE_DEPTH) begin
      k = load_cnt;
      b = (w.burst_length == 8'd0) ? 8'd1 : w.burst_length;
      tbl_pid[k]       = w.proc_id;
      tbl_arrival[k]   = w.arrival_tick;
      tbl_burst[k]     = b;
      tbl_remaining[k] = b;
      tbl_prio[k]      = w.prio_level;
      tbl_started[k]   = 1'b0;
      tbl_done[k]      = 1'b0;
      tbl_start[k]     = '0;
      load_cnt         = load_cnt + 5'd1;
    end
    if (w.last_entry) begin
      run_schedule();
      clear_table();
    end
  endtask

  task automatic push_word(int pid, int arr, int burst, int prio, bit last, bit drain);
    proc_word_t w;
    w.proc_id        = pid[7:0];
    w.arrival_tick   = arr[15:0];
    w.burst_length   = burst[7:0];
    w.prio_level     = prio[7:0];
    w.last_entry     = last;
    w.hold_for_drain = drain;
    pending_q.push_back(w);
  endtask

  task automatic queue_random_set(int n, bit drain);
    int i;
    int arr;
    int burst;
    int prio;
    for (i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0:       arr = $urandom_range(0, 65535);
        1:       arr = 65535 - $urandom_range(0, 20);
        default: arr = $urandom_range(0, 40);
      endcase
      case ($urandom_range(0, 39))
        0:       burst = 0;
        1:       burst = 255;
        2, 3:    burst = $urandom_range(0, 255);
        default: burst = $urandom_range(1, 8);
      endcase
      prio = $urandom_range(0, 1) ? $urandom_range(0, 255) : $urandom_range(0, 3);
      push_word($urandom_range(0, 255), arr, burst, prio, i == n - 1, drain && i == 0);
    end
  endtask

  // driver
  always @(posedge clk) begin
    logic       valid_n;
    int         send_gap;
    proc_word_t cur;
    if (rst_n) begin
      valid_n = in_valid;
      if (in_valid && in_ready) begin
        take_process(cur);
        items_taken++;
        valid_n = 1'b0;
      end
      if (!valid_n) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_q.size() > 0 &&
                     !(pending_q[0].hold_for_drain && completion_q.size() != 0)) begin
          cur = pending_q.pop_front();
          in_proc_id      <= cur.proc_id;
          in_arrival_tick <= cur.arrival_tick;
          in_burst_length <= cur.burst_length;
          in_prio_level   <= cur.prio_level;
          in_last_entry   <= cur.last_entry;
          valid_n  = 1'b1;
          send_gap = draw_gap();
        end
      end
      in_valid <= valid_n;
    end
  end

  // monitor
  always @(posedge clk) begin
    int          stall;
    completion_t got;
    completion_t exp_word;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got.done_id        = out_done_id;
        got.start_tick     = out_start_tick;
        got.finish_tick    = out_finish_tick;
        got.turnaround     = out_turnaround;
        got.wait_ticks     = out_wait_ticks;
        got.sum_turnaround = out_sum_turnaround;
        got.sum_wait       = out_sum_wait;
        got.last_result    = out_last_result;
        if (completion_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: unexpected word id=%0d finish=%0d", $realtime, got.done_id,
                     got.finish_tick);
        end else begin
          exp_word = completion_q.pop_front();
          if (got !== exp_word) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("%0t: mismatch exp id=%0d start=%0d fin=%0d turn=%0d wait=%0d",
                       $realtime, exp_word.done_id, exp_word.start_tick,
                       exp_word.finish_tick, exp_word.turnaround, exp_word.wait_ticks);
              $display("    exp sum_turn=%0d sum_wait=%0d last=%0d",
                       exp_word.sum_turnaround, exp_word.sum_wait, exp_word.last_result);
              $display("    act id=%0d start=%0d fin=%0d turn=%0d wait=%0d",
                       got.done_id, got.start_tick, got.finish_tick, got.turnaround,
                       got.wait_ticks);
              $display("    act sum_turn=%0d sum_wait=%0d last=%0d",
                       got.sum_turnaround, got.sum_wait, got.last_result);
            end
          end
        end
        stall = draw_gap();
      end else if (stall > 0) begin
        stall--;
      end
      out_ready <= (stall == 0);
    end
  end

  // watchdog, plus calm spells with no gaps on either side
  always @(posedge clk) begin
    int idle_cycles;
    int cycle_cnt;
    if (rst_n) begin
      cycle_cnt++;
      if (cycle_cnt % 256 == 0)
        calm = ($urandom_range(0, 3) == 0);
      if ((in_valid && in_ready) || (out_valid && out_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    int n;
    int random_items;
    int i;
    clear_table();
    // field extremes, one entry each
    push_word(0, 0, 1, 0, 1, 0);
    push_word(255, 65535, 255, 255, 1, 0);
    // preemption by a later, higher priority arrival; zero burst
    push_word(1, 0, 5, 1, 0, 0);
    push_word(2, 2, 0, 9, 1, 0);
    // equal priority: earlier arrival, then load order
    push_word(3, 3, 2, 5, 0, 0);
    push_word(4, 1, 2, 5, 0, 0);
    push_word(5, 1, 2, 5, 1, 0);
    // idle stretches
    push_word(6, 10, 3, 7, 0, 0);
    push_word(7, 1000, 2, 2, 1, 0);
    // table overflow: the seventeenth word is dropped but starts the run
    for (i = 0; i < TABLE_DEPTH + 1; i++)
      push_word(16 + i, (i % 4) * 3, (i % 3) + 1, i % 5, i == TABLE_DEPTH, 0);
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       n = $urandom_range(17, 20);
        1, 2:    n = $urandom_range(7, 16);
        default: n = $urandom_range(1, 6);
      endcase
      queue_random_set(n, random_items == 0 || $urandom_range(0, 24) == 0);
      random_items += (n > TABLE_DEPTH) ? TABLE_DEPTH : n;
    end
    items_total = pending_q.size();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    while (items_taken < items_total) @(posedge clk);
    while (completion_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && completion_q.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
src/pps_pkg.sv
src/pps_table.sv
src/pps_pick.sv
src/preemptive_priority_scheduler.sv
tb/preemptive_priority_scheduler_tb.sv
